### sv/cavity_lock_sweep_controller_core_defines.svh
// assertion macros for the cavity lock sweep controller
// included by files that carry concurrent checks; no other dependencies
`ifndef CAVITY_LOCK_SWEEP_CONTROLLER_CORE_DEFINES_SVH
`define CAVITY_LOCK_SWEEP_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
// check under reset qualification
`define CLSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clsc check failed");
// check that also holds during reset
`define CLSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("clsc check failed");
`else
`define CLSC_ASSERT(label, clk, rst, prop)
`define CLSC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### sv/clsc_pkg.sv
// shared types and constants for the cavity lock sweep controller
// no dependencies; used by clsc_update, the core top level and the testbench
package clsc_pkg;

  // operating modes
  localparam logic [1:0] MODE_RELOCK    = 2'd0;
  localparam logic [1:0] MODE_SWEEP     = 2'd1;
  localparam logic [1:0] MODE_FORCE_ON  = 2'd2;
  localparam logic [1:0] MODE_FORCE_OFF = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MIN = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MAX = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_MIN  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_MAX  = 3'd5;

  // reported lock state codes
  localparam logic [1:0] LS_ACQUIRE = 2'd0;
  localparam logic [1:0] LS_SCAN    = 2'd1;
  localparam logic [1:0] LS_LOCKED  = 2'd2;
  localparam logic [1:0] LS_WAIT    = 2'd3;

  typedef enum logic [3:0] {
    RS_ACQUIRE = 4'b0001,
    RS_SCAN    = 4'b0010,
    RS_LOCKED  = 4'b0100,
    RS_WAIT    = 4'b1000
  } run_state_t;

  // configuration reset values
  localparam logic [1:0]         MODE_RST       = MODE_RELOCK;
  localparam logic signed [15:0] WINDOW_MIN_RST = 16'sd2048;
  localparam logic signed [15:0] WINDOW_MAX_RST = 16'sd4096;
  localparam logic signed [12:0] STEP_SIZE_RST  = 13'sd20;
  localparam logic signed [15:0] SWEEP_MIN_RST  = -16'sd5100;
  localparam logic signed [15:0] SWEEP_MAX_RST  = 16'sd5100;

  // servo dead band, 0.1 V
  localparam logic signed [15:0] SERVO_DEADBAND = 16'sd205;

  // acquire amplitude floor((614400 + 2048*count) / 3000) kept as quotient and remainder
  localparam int unsigned        AMP_BASE = 204;
  localparam logic [11:0]        REM_BASE = 12'd2400;
  localparam logic [11:0]        REM_STEP = 12'd2048;
  localparam logic [12:0]        REM_DIV  = 13'd3000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] window_min;
    logic signed [15:0] window_max;
    logic signed [12:0] step_size;
    logic signed [15:0] sweep_min;
    logic signed [15:0] sweep_max;
  } cfg_t;

endpackage

### sv/cavity_lock_sweep_controller_core.sv
// top level of the cavity lock sweep controller: handshake, registers, state
// depends on clsc_pkg, clsc_update and cavity_lock_sweep_controller_core_defines.svh
`include "cavity_lock_sweep_controller_core_defines.svh"

// Cavity lock sweep controller. Each input beat carries one cavity sample, one servo
// sample and the dependency-fault bit, and gives exactly one result beat with the new
// sweep output, the integrator-disable fault and the lock state. A beat is taken every
// clock cycle when the output side keeps up; each beat passes through the input
// register and then the result register, and the result register parts the two
// sides so one more beat is still taken into the input register while a result waits
// to be collected. The rate is set by the combinational loop through clsc_update,
// which reads and rewrites the sweep, last locked point, direction, ramp counter and
// fault state each beat. The acquire amplitude, 0.1 V plus count/3000 V, is carried
// as a running quotient and remainder, so no divider is needed. Configuration is
// written through the plain write port; the user must write it only while no beat
// is in flight, which the block does not enforce. Writes to indexes beyond the sweep
// maximum are ignored. All voltages are signed fixed point at 1/2048 V.
module cavity_lock_sweep_controller_core import clsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  // sample beats
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        cavity_sample,
  input  logic signed [15:0]        servo_sample,
  input  logic                      dependency_fault,
  // result beats
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        sweep_out,
  output logic                      integrator_disable,
  output logic [1:0]                lock_state
);

  // configuration registers
  cfg_t cfg;

  // input register
  logic               s1_valid;
  logic signed [15:0] s1_cavity;
  logic signed [15:0] s1_servo;
  logic               s1_dep_fault;

  // controller state
  logic signed [15:0]    sweep_value, sweep_value_next;
  logic signed [15:0]    last_locked_value, last_locked_value_next;
  logic                  scan_direction, scan_direction_next;
  logic [COUNT_BITS-1:0] acquire_count, acquire_count_next;
  logic [COUNT_BITS-1:0] amp, amp_next;        // current acquire half-width
  logic [11:0]           amp_rem, amp_rem_next; // remainder of the amplitude division
  logic                  fault_flag, fault_flag_next;
  logic [1:0]            lock_state_next;

  logic out_free;
  logic advance;

  // the result register is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_RST;
      cfg.window_min <= WINDOW_MIN_RST;
      cfg.window_max <= WINDOW_MAX_RST;
      cfg.step_size  <= STEP_SIZE_RST;
      cfg.sweep_min  <= SWEEP_MIN_RST;
      cfg.sweep_max  <= SWEEP_MAX_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE:       cfg.mode       <= cfg_data[1:0];
        CFG_WINDOW_MIN: cfg.window_min <= $signed(cfg_data);
        CFG_WINDOW_MAX: cfg.window_max <= $signed(cfg_data);
        CFG_STEP_SIZE:  cfg.step_size  <= $signed(cfg_data[12:0]);
        CFG_SWEEP_MIN:  cfg.sweep_min  <= $signed(cfg_data);
        CFG_SWEEP_MAX:  cfg.sweep_max  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cavity    <= cavity_sample;
      s1_servo     <= servo_sample;
      s1_dep_fault <= dependency_fault;
    end
  end

  // one beat of the lock and sweep update
  clsc_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .cfg                    (cfg),
    .cavity_sample          (s1_cavity),
    .servo_sample           (s1_servo),
    .dependency_fault       (s1_dep_fault),
    .sweep_value            (sweep_value),
    .last_locked_value      (last_locked_value),
    .scan_direction         (scan_direction),
    .acquire_count          (acquire_count),
    .amp                    (amp),
    .amp_rem                (amp_rem),
    .fault_flag             (fault_flag),
    .sweep_value_next       (sweep_value_next),
    .last_locked_value_next (last_locked_value_next),
    .scan_direction_next    (scan_direction_next),
    .acquire_count_next     (acquire_count_next),
    .amp_next               (amp_next),
    .amp_rem_next           (amp_rem_next),
    .fault_flag_next        (fault_flag_next),
    .lock_state             (lock_state_next)
  );

  // state advances only as a beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_value       <= '0;
      last_locked_value <= '0;
      scan_direction    <= 1'b1;
      acquire_count     <= '0;
      amp               <= COUNT_BITS'(AMP_BASE);
      amp_rem           <= REM_BASE;
      fault_flag        <= 1'b1;
    end else if (advance) begin
      sweep_value       <= sweep_value_next;
      last_locked_value <= last_locked_value_next;
      scan_direction    <= scan_direction_next;
      acquire_count     <= acquire_count_next;
      amp               <= amp_next;
      amp_rem           <= amp_rem_next;
      fault_flag        <= fault_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sweep_out          <= sweep_value_next;
      integrator_disable <= fault_flag_next;
      lock_state         <= lock_state_next;
    end
  end

  // checks
  logic amp_at_base;
  logic out_locked;
  logic out_acquire;
  logic range_checked;
  logic sweep_in_limits;

  assign amp_at_base     = (amp == COUNT_BITS'(AMP_BASE)) && (amp_rem == REM_BASE);
  assign out_locked      = out_valid && (lock_state == LS_LOCKED);
  assign out_acquire     = out_valid && (lock_state == LS_ACQUIRE);
  // a held acquire beat keeps the old value, which may sit outside newly written limits
  assign range_checked   = out_valid && (cfg.sweep_min <= cfg.sweep_max)
                           && (lock_state != LS_ACQUIRE);
  assign sweep_in_limits = (sweep_out >= cfg.sweep_min) && (sweep_out <= cfg.sweep_max);

  // ramp counter at zero means the amplitude sits at its 0.1 V start
  `CLSC_ASSERT(a_amp_base, clk, rst, (acquire_count == '0) |-> amp_at_base)
  // a delivered locked beat always enables the integrator, acquire always disables it
  `CLSC_ASSERT(a_locked_fault, clk, rst, out_locked |-> !integrator_disable)
  `CLSC_ASSERT(a_acquire_fault, clk, rst, out_acquire |-> integrator_disable)
  // with sane limits the clamped sweep stays within them
  `CLSC_ASSERT(a_sweep_range, clk, rst, range_checked |-> sweep_in_limits)

endmodule

### sv/clsc_update.sv
// per-beat state update of the cavity lock sweep controller
// depends on clsc_pkg; purely combinational
module clsc_update import clsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  cfg_t                    cfg,
  input  logic signed [15:0]      cavity_sample,
  input  logic signed [15:0]      servo_sample,
  input  logic                    dependency_fault,
  input  logic signed [15:0]      sweep_value,
  input  logic signed [15:0]      last_locked_value,
  input  logic                    scan_direction,
  input  logic [COUNT_BITS-1:0]   acquire_count,
  input  logic [COUNT_BITS-1:0]   amp,
  input  logic [11:0]             amp_rem,
  input  logic                    fault_flag,
  output logic signed [15:0]      sweep_value_next,
  output logic signed [15:0]      last_locked_value_next,
  output logic                    scan_direction_next,
  output logic [COUNT_BITS-1:0]   acquire_count_next,
  output logic [COUNT_BITS-1:0]   amp_next,
  output logic [11:0]             amp_rem_next,
  output logic                    fault_flag_next,
  output logic [1:0]              lock_state
);

  localparam int unsigned CW = ((COUNT_BITS > 21) ? COUNT_BITS : 21) + 2;

  run_state_t         run;
  logic               in_window;
  logic               skip;
  logic signed [CW-1:0] v, step_w, step100, hi, lo, smin, smax, llv_w, amp_w;
  logic [12:0]        rem_sum;

  assign in_window = !dependency_fault && (cavity_sample >= cfg.window_min)
                     && (cavity_sample <= cfg.window_max);

  assign step_w  = CW'(cfg.step_size);
  assign step100 = (step_w <<< 6) + (step_w <<< 5) + (step_w <<< 2);
  assign smin    = CW'(cfg.sweep_min);
  assign smax    = CW'(cfg.sweep_max);
  assign llv_w   = CW'(last_locked_value);
  assign amp_w   = $signed({{(CW-COUNT_BITS){1'b0}}, amp});
  assign hi      = llv_w + amp_w;
  assign lo      = llv_w - amp_w;
  assign rem_sum = {1'b0, amp_rem} + {1'b0, REM_STEP};

  always_comb begin
    run                    = RS_ACQUIRE;
    skip                   = 1'b0;
    v                      = CW'(sweep_value);
    last_locked_value_next = last_locked_value;
    scan_direction_next    = scan_direction;
    acquire_count_next     = acquire_count;
    amp_next               = amp;
    amp_rem_next           = amp_rem;
    fault_flag_next        = fault_flag;

    // run state
    case (cfg.mode)
      MODE_RELOCK: begin
        if (in_window) begin
          run                    = RS_LOCKED;
          last_locked_value_next = sweep_value;
        end else begin
          run = RS_ACQUIRE;
        end
      end
      MODE_SWEEP: run = RS_SCAN;
      default:    run = RS_WAIT;
    endcase

    // integrator fault
    case (cfg.mode)
      MODE_FORCE_ON:  fault_flag_next = 1'b0;
      MODE_FORCE_OFF: fault_flag_next = 1'b1;
      MODE_RELOCK:    fault_flag_next = !in_window;
      default:        fault_flag_next = fault_flag;
    endcase

    // sweep
    case (run)
      RS_ACQUIRE: begin
        if (dependency_fault) begin
          skip = 1'b1;
        end else begin
          v = scan_direction ? (v + step_w) : (v - step_w);
          if (v > hi) begin
            scan_direction_next = !scan_direction_next;
            v = hi;
          end
          if (v < lo) begin
            scan_direction_next = !scan_direction_next;
            v = lo;
          end
          if (!(&acquire_count)) begin
            acquire_count_next = acquire_count + COUNT_BITS'(1);
            if (rem_sum >= REM_DIV) begin
              amp_next     = amp + COUNT_BITS'(1);
              amp_rem_next = 12'(rem_sum - REM_DIV);
            end else begin
              amp_rem_next = rem_sum[11:0];
            end
          end
        end
      end
      RS_SCAN: begin
        v = scan_direction ? (v + step100) : (v - step100);
        if (v > smax) begin
          scan_direction_next = !scan_direction_next;
          v = smax;
        end
        if (v < smin) begin
          scan_direction_next = !scan_direction_next;
          v = smin;
        end
      end
      RS_LOCKED: begin
        if (servo_sample >= SERVO_DEADBAND) v = v + step_w;
        if (servo_sample <= -SERVO_DEADBAND) v = v - step_w;
      end
      default: v = llv_w;
    endcase

    // any state but acquire restarts the amplitude ramp
    if (run != RS_ACQUIRE) begin
      acquire_count_next = '0;
      amp_next           = COUNT_BITS'(AMP_BASE);
      amp_rem_next       = REM_BASE;
    end

    // out of range falls back to zero, then clamp
    if (!skip) begin
      if (v > smax || v < smin) begin
        last_locked_value_next = '0;
        v                      = '0;
        acquire_count_next     = '0;
        amp_next               = COUNT_BITS'(AMP_BASE);
        amp_rem_next           = REM_BASE;
      end
      if (v > smax) v = smax;
      if (v < smin) v = smin;
    end
    sweep_value_next = v[15:0];
  end

  always_comb begin
    case (run)
      RS_ACQUIRE: lock_state = LS_ACQUIRE;
      RS_SCAN:    lock_state = LS_SCAN;
      RS_LOCKED:  lock_state = LS_LOCKED;
      RS_WAIT:    lock_state = LS_WAIT;
      default:    lock_state = LS_ACQUIRE;
    endcase
  end

endmodule

### tb/sv/sweep_lock_checker.sv
// checker for the cavity lock sweep controller: tracks register writes, predicts each
// result beat from the accepted sample beats and compares. depends on clsc_pkg
`timescale 1ns / 100ps

module sweep_lock_checker import clsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        cavity_sample,
  input  logic signed [15:0]        servo_sample,
  input  logic                      dependency_fault,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [15:0]        sweep_out,
  input  logic                      integrator_disable,
  input  logic [1:0]                lock_state,
  output int                        mismatch_count,
  output int                        beats_in_flight
);

  localparam longint RAMP_MAX   = (longint'(1) << COUNT_BITS) - 1;
  localparam longint AMP_OFFSET = 614400;
  localparam longint AMP_SCALE  = 2048;
  localparam longint AMP_DIV    = 3000;
  localparam longint SCAN_GAIN  = 100;
  localparam longint DEAD_BAND  = 205;

  typedef struct packed {
    logic signed [15:0] sweep;
    logic               int_off;
    logic [1:0]         state;
  } sweep_beat_t;

  // register copy
  logic [1:0] mode_r;
  longint     win_lo, win_hi, step, lim_lo, lim_hi;

  // controller state copy
  logic [1:0] run_st;
  longint     sweep_pos, locked_pos, ramp_count;
  logic       upward;
  logic       int_off;

  sweep_beat_t expected_beats[$];
  int          error_total = 0;

  task automatic reset_model();
    mode_r     = MODE_RELOCK;
    win_lo     = 2048;
    win_hi     = 4096;
    step       = 20;
    lim_lo     = -5100;
    lim_hi     = 5100;
    run_st     = LS_ACQUIRE;
    sweep_pos  = 0;
    locked_pos = 0;
    ramp_count = 0;
    upward     = 1'b1;
    int_off    = 1'b1;
    expected_beats.delete();
  endtask

  task automatic predict_sweep(input longint cav, input longint servo, input logic dep,
                               output sweep_beat_t r);
    longint v, amp, lo, hi;
    logic   hold;
    hold = 1'b0;
    v    = sweep_pos;
    case (mode_r)
      MODE_RELOCK: begin
        if (!dep && cav >= win_lo && cav <= win_hi) begin
          run_st     = LS_LOCKED;
          ramp_count = 0;
          locked_pos = sweep_pos;
        end else begin
          run_st = LS_ACQUIRE;
        end
      end
      MODE_SWEEP: run_st = LS_SCAN;
      default:    run_st = LS_WAIT;
    endcase

    if (mode_r == MODE_FORCE_ON) int_off = 1'b0;
    else if (mode_r == MODE_FORCE_OFF) int_off = 1'b1;
    else if (run_st == LS_LOCKED) int_off = 1'b0;
    else if (run_st == LS_ACQUIRE) int_off = 1'b1;

    if (run_st == LS_ACQUIRE) begin
      // sweep frozen while the upstream locker is out
      if (dep) begin
        hold = 1'b1;
      end else begin
        amp = (AMP_OFFSET + AMP_SCALE * ramp_count) / AMP_DIV;
        lo  = locked_pos - amp;
        hi  = locked_pos + amp;
        v  += upward ? step : -step;
        if (v > hi) begin
          upward = !upward;
          v      = hi;
        end
        if (v < lo) begin
          upward = !upward;
          v      = lo;
        end
        if (ramp_count < RAMP_MAX) ramp_count++;
      end
    end else begin
      ramp_count = 0;
      case (run_st)
        LS_SCAN: begin
          v += upward ? SCAN_GAIN * step : -SCAN_GAIN * step;
          if (v > lim_hi) begin
            upward = !upward;
            v      = lim_hi;
          end
          if (v < lim_lo) begin
            upward = !upward;
            v      = lim_lo;
          end
        end
        LS_LOCKED: begin
          if (servo >= DEAD_BAND) v += step;
          if (servo <= -DEAD_BAND) v -= step;
        end
        default: v = locked_pos;
      endcase
    end

    if (!hold) begin
      if (v > lim_hi || v < lim_lo) begin
        locked_pos = 0;
        v          = 0;
        ramp_count = 0;
      end
      if (v > lim_hi) v = lim_hi;
      if (v < lim_lo) v = lim_lo;
      sweep_pos = v;
    end

    r.sweep   = 16'(sweep_pos);
    r.int_off = int_off;
    r.state   = run_st;
  endtask

  always @(posedge clk) begin : watch
    sweep_beat_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no sample beat waiting for it");
          error_total++;
        end else begin
          want = expected_beats.pop_front();
          if (sweep_out !== want.sweep) begin
            $error("sweep_out expected %0d got %0d", want.sweep, sweep_out);
            error_total++;
          end
          if (integrator_disable !== want.int_off) begin
            $error("integrator_disable expected %0d got %0d", want.int_off,
                   integrator_disable);
            error_total++;
          end
          if (lock_state !== want.state) begin
            $error("lock_state expected %0d got %0d", want.state, lock_state);
            error_total++;
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_MODE:       mode_r = cfg_data[1:0];
          CFG_WINDOW_MIN: win_lo = longint'($signed(cfg_data));
          CFG_WINDOW_MAX: win_hi = longint'($signed(cfg_data));
          CFG_STEP_SIZE:  step   = longint'($signed(cfg_data[12:0]));
          CFG_SWEEP_MIN:  lim_lo = longint'($signed(cfg_data));
          CFG_SWEEP_MAX:  lim_hi = longint'($signed(cfg_data));
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        predict_sweep(longint'(cavity_sample), longint'(servo_sample), dependency_fault,
                      want);
        expected_beats.insert(expected_beats.size(), want);
      end
    end
    mismatch_count  <= error_total;
    beats_in_flight <= expected_beats.size();
  end

endmodule

### tb/sv/tb_top.sv
// stimulus and verdict for the cavity lock sweep controller
// depends on clsc_pkg, cavity_lock_sweep_controller_core and sweep_lock_checker
`timescale 1ns / 100ps

module tb_top import clsc_pkg::*; ();

  // indexes past the last register, writes there must leave everything alone
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  // generous ceiling, the slowest legal run stays far below it
  localparam int CYCLE_LIMIT = 400000;
  // extra wait after the input and result registers drain, before touching registers
  localparam int SETTLE_CYCLES = 4;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_MODE;
  logic [15:0]               cfg_data = 16'd0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [15:0]        cavity_sample = 16'sd0;
  logic signed [15:0]        servo_sample = 16'sd0;
  logic                      dependency_fault = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [15:0]        sweep_out;
  logic                      integrator_disable;
  logic [1:0]                lock_state;

  int mismatches;
  int beats_in_flight;
  int cycle_count = 0;

  // sender burst shaping
  int burst_left = 0;
  bit tx_calm = 1'b0;

  // window currently programmed, used to aim cavity samples in or out of it
  int cur_wlo = 2048;
  int cur_whi = 4096;

  // receiver stall pattern
  logic [31:0] rx_tick = 32'd0;
  int          rx_style = 0;
  int          rx_hold = 0;

  cavity_lock_sweep_controller_core #(.COUNT_BITS(20)) u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .cavity_sample      (cavity_sample),
    .servo_sample       (servo_sample),
    .dependency_fault   (dependency_fault),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .sweep_out          (sweep_out),
    .integrator_disable (integrator_disable),
    .lock_state         (lock_state)
  );

  sweep_lock_checker #(.COUNT_BITS(20)) u_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .cavity_sample      (cavity_sample),
    .servo_sample       (servo_sample),
    .dependency_fault   (dependency_fault),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .sweep_out          (sweep_out),
    .integrator_disable (integrator_disable),
    .lock_state         (lock_state),
    .mismatch_count     (mismatches),
    .beats_in_flight    (beats_in_flight)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: the style is redrawn each time the tick counter's low bits wrap, from always ready through
  // light and heavy random stalls to long alternating runs of stall and accept
  always @(posedge clk) begin
    rx_tick <= rx_tick + 32'd1;
    if (rx_tick[6:0] == 7'd0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
        end else begin
          out_ready <= !out_ready;
          rx_hold   <= out_ready ? $urandom_range(1, 30) : $urandom_range(1, 10);
        end
      end
    endcase
  end

  // one sample beat; valid holds until the block takes it, then a random gap may follow
  // unless this phase runs without idling
  task automatic send_sample(input logic signed [15:0] cav, input logic signed [15:0] srv,
                             input logic dep);
    cavity_sample    <= cav;
    servo_sample     <= srv;
    dependency_fault <= dep;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!tx_calm) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait until every predicted beat has come back
  task automatic wait_settled();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // full register set, only ever written with the pipeline empty
  task automatic set_regs(input logic [1:0] md, input int wlo, input int whi, input int stp,
                          input int slo, input int shi);
    wait_settled();
    write_reg(CFG_MODE, 16'(md));
    write_reg(CFG_WINDOW_MIN, 16'(wlo));
    write_reg(CFG_WINDOW_MAX, 16'(whi));
    write_reg(CFG_STEP_SIZE, 16'(stp));
    write_reg(CFG_SWEEP_MIN, 16'(slo));
    write_reg(CFG_SWEEP_MAX, 16'(shi));
    cfg_write <= 1'b0;
    cur_wlo = wlo;
    cur_whi = whi;
  endtask

  // servo values: full range, hugging the dead band edges, or small
  function automatic logic signed [15:0] pick_servo();
    int sel;
    sel = $urandom_range(0, 2);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(203, 207)));
    return 16'(int'($urandom_range(0, 800)) - 400);
  endfunction

  // runs of one flavour: locking samples, samples outside the window, upstream
  // fault, or plain noise; long runs let the acquire ramp turn a few times
  task automatic random_phase(input int n_beats);
    int                 kind;
    int                 run_left;
    logic signed [15:0] cav;
    logic               dep;
    run_left = 0;
    kind     = 0;
    tx_calm  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_beats; i++) begin
      if (run_left == 0) begin
        kind     = $urandom_range(0, 9);
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      if (kind <= 3) begin
        if (cur_wlo <= cur_whi) cav = 16'(cur_wlo + int'($urandom_range(0, cur_whi - cur_wlo)));
        else cav = 16'($urandom);
        dep = ($urandom_range(0, 15) == 0);
      end else if (kind <= 6) begin
        cav = 16'($urandom);
        if (cav >= cur_wlo && cav <= cur_whi) cav = 16'(cur_whi + 1);
        dep = 1'b0;
      end else if (kind == 7) begin
        cav = 16'($urandom);
        dep = 1'b1;
      end else begin
        cav = 16'($urandom);
        dep = 1'($urandom_range(0, 1));
      end
      send_sample(cav, pick_servo(), dep);
    end
  endtask

  initial begin : stimulus
    logic [1:0] md;
    int         wlo, whi, stp, slo, shi;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, dead band edges, window edges, upstream fault
    set_regs(MODE_RELOCK, 2048, 4096, 20, -5100, 5100);
    tx_calm = 1'b1;
    send_sample(16'sd3000, 16'sd0, 1'b0);
    send_sample(16'sd3000, 16'sd205, 1'b0);
    send_sample(16'sd3000, 16'sd204, 1'b0);
    send_sample(16'sd3000, -16'sd205, 1'b0);
    send_sample(16'sd3000, -16'sd204, 1'b0);
    send_sample(16'sd3000, 16'sh7fff, 1'b0);
    send_sample(16'sd3000, 16'sh8000, 1'b0);
    send_sample(16'sd2048, 16'sd205, 1'b0);
    send_sample(16'sd4096, 16'sd205, 1'b0);
    send_sample(16'sd2047, 16'sd0, 1'b0);
    send_sample(16'sd4097, 16'sd0, 1'b0);
    send_sample(16'sd3000, 16'sd0, 1'b1);
    send_sample(16'sh8000, 16'sd0, 1'b0);
    send_sample(16'sh7fff, 16'sd0, 1'b1);

    // writes past the last register must be ignored
    wait_settled();
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'h0001);
    cfg_write <= 1'b0;
    send_sample(16'sd3000, 16'sd300, 1'b0);

    // scan and both forced integrator modes
    set_regs(MODE_SWEEP, 2048, 4096, 20, -5100, 5100);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd3000, 16'sd0, 1'b1);
    set_regs(MODE_FORCE_ON, 2048, 4096, 20, -5100, 5100);
    send_sample(16'sd3000, 16'sd0, 1'b0);
    set_regs(MODE_FORCE_OFF, 2048, 4096, 20, -5100, 5100);
    send_sample(16'sd3000, 16'sd0, 1'b1);

    // big locked step out of a narrow range, then inverted sweep limits
    set_regs(MODE_RELOCK, 2048, 4096, 2048, -100, 100);
    send_sample(16'sd3000, 16'sh7fff, 1'b0);
    send_sample(16'sd3000, 16'sh8000, 1'b0);
    set_regs(MODE_RELOCK, 2048, 4096, 20, 100, -100);
    send_sample(16'sd3000, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);

    // fixed settings, extremes among them
    set_regs(MODE_RELOCK, 2048, 4096, 20, -5100, 5100);
    random_phase(250);
    set_regs(MODE_RELOCK, -20480, 20480, 2048, -20480, 20480);
    random_phase(120);
    set_regs(MODE_RELOCK, -300, 300, -2048, -20480, 20480);
    random_phase(100);
    set_regs(MODE_RELOCK, 1000, 1200, 1, -20480, 20480);
    random_phase(120);
    set_regs(MODE_SWEEP, 0, 0, 2048, -20480, 20480);
    random_phase(80);
    set_regs(MODE_SWEEP, 0, 0, -7, -20480, 20480);
    random_phase(80);
    set_regs(MODE_SWEEP, 0, 0, 30, 20480, -20480);
    random_phase(40);
    set_regs(MODE_FORCE_ON, 20480, -20480, -2048, -20480, 20480);
    random_phase(60);
    set_regs(MODE_FORCE_OFF, -20480, -20480, 2048, -3000, 3000);
    random_phase(60);
    // inverted window and zero step
    set_regs(MODE_RELOCK, 500, -500, 0, -1000, 1000);
    random_phase(60);
    // single point window and single point sweep range at the bottom
    set_regs(MODE_RELOCK, -20480, -20480, 2048, -20480, -20480);
    random_phase(40);

    // random settings, auto mode favoured
    for (int p = 0; p < 8; p++) begin
      md  = $urandom_range(0, 1) ? MODE_RELOCK : 2'($urandom_range(0, 3));
      wlo = int'($urandom_range(0, 40960)) - 20480;
      if ($urandom_range(0, 9) == 0) whi = wlo - int'($urandom_range(1, 500));
      else whi = wlo + int'($urandom_range(0, 6000));
      if (whi > 20480) whi = 20480;
      if (whi < -20480) whi = -20480;
      stp = int'($urandom_range(0, 4096)) - 2048;
      if ($urandom_range(0, 1)) stp = stp / 16;
      slo = -int'($urandom_range(0, 20480));
      shi = int'($urandom_range(0, 20480));
      set_regs(md, wlo, whi, stp, slo, shi);
      random_phase(70);
    end

    wait_settled();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### cavity_lock_sweep_controller_core.f
+incdir+sv
sv/clsc_pkg.sv
sv/clsc_update.sv
sv/cavity_lock_sweep_controller_core.sv
tb/sv/sweep_lock_checker.sv
tb/sv/tb_top.sv
